// ----- sv/teet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teet_pkg
// Shared codes, field widths and cell interface structs for the timed event
// expiry table.
// ----------------------------------------------------------------------------
package teet_pkg;

  localparam int OP_W     = 3;
  localparam int ID_W     = 16;
  localparam int IN_TIME_W = 32;
  localparam int STATUS_W = 2;
  localparam int PCOUNT_W = 5;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REARM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic load_hit;    // re-arm the matching cell
    logic load_free;   // fill the first free cell
    logic set_delay;   // change delay of the matching cell
    logic kill_hit;    // free the matching cell
    logic clear_all;   // free every cell
    logic tick_mark;   // free expired cells and flag them for counting and output
    logic cnt_step;    // first cell with a count flag drops it
    logic emit_step;   // first cell with an emit flag drops it
  } cell_ctl_t;

  // Carried from cell to cell: "some earlier cell has this flag".
  typedef struct packed {
    logic free_seen;
    logic cnt_seen;
    logic emit_seen;
  } chain_t;

  // Per-cell status seen by the controller.
  typedef struct packed {
    logic match;
    logic emit_rest;   // emit flag set behind an earlier one
    logic cnt_flag;
    logic emit_flag;
  } cell_stat_t;

endpackage

// ----- sv/teet_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teet_cell
// One table slot: key, start time, delay and valid, plus the expiry flags
// used to count and output expired events in slot order.
// ----------------------------------------------------------------------------
module teet_cell #(
  parameter int TIME_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  teet_pkg::cell_ctl_t     ctl,
  input  logic [15:0]             cmd_key,
  input  logic [TIME_BITS-1:0]    cmd_now,
  input  logic [TIME_BITS-1:0]    cmd_delay,
  input  teet_pkg::chain_t        chain_in,
  output teet_pkg::chain_t        chain_out,
  output teet_pkg::cell_stat_t    stat,
  output logic [15:0]             key_out
);
  import teet_pkg::*;

  logic                 valid_r, valid_nxt;
  logic                 cnt_r, cnt_nxt;
  logic                 emit_r, emit_nxt;
  logic [ID_W-1:0]      key_r, key_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] delay_r, delay_nxt;
  logic [TIME_BITS:0]   deadline;
  logic                 match, expired, take_free, take_cnt, take_emit;

  // The deadline keeps its carry, so a sum past the time range never expires.
  assign deadline  = {1'b0, start_r} + {1'b0, delay_r};
  assign expired   = valid_r && (deadline < {1'b0, cmd_now});
  assign match     = valid_r && (key_r == cmd_key);
  assign take_free = !valid_r && !chain_in.free_seen;
  assign take_cnt  = cnt_r && !chain_in.cnt_seen;
  assign take_emit = emit_r && !chain_in.emit_seen;

  assign chain_out.free_seen = chain_in.free_seen || !valid_r;
  assign chain_out.cnt_seen  = chain_in.cnt_seen || cnt_r;
  assign chain_out.emit_seen = chain_in.emit_seen || emit_r;

  assign stat.match     = match;
  assign stat.emit_rest = emit_r && chain_in.emit_seen;
  assign stat.cnt_flag  = cnt_r;
  assign stat.emit_flag = emit_r;
  assign key_out        = take_emit ? key_r : '0;

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    emit_nxt  = emit_r;
    key_nxt   = key_r;
    start_nxt = start_r;
    delay_nxt = delay_r;
    if (ctl.clear_all) begin
      valid_nxt = 1'b0;
    end
    if (ctl.load_free && take_free) begin
      valid_nxt = 1'b1;
      key_nxt   = cmd_key;
      start_nxt = cmd_now;
      delay_nxt = cmd_delay;
    end
    if (ctl.load_hit && match) begin
      start_nxt = cmd_now;
      delay_nxt = cmd_delay;
    end
    if (ctl.set_delay && match) begin
      delay_nxt = cmd_delay;
    end
    if (ctl.kill_hit && match) begin
      valid_nxt = 1'b0;
    end
    if (ctl.tick_mark) begin
      cnt_nxt  = expired;
      emit_nxt = expired;
      if (expired) begin
        valid_nxt = 1'b0;
      end
    end
    if (ctl.cnt_step && take_cnt) begin
      cnt_nxt = 1'b0;
    end
    if (ctl.emit_step && take_emit) begin
      emit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    start_r <= start_nxt;
    delay_r <= delay_nxt;
  end

endmodule

// ----- sv/timed_event_expiry_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_expiry_table_unit
// Table of pending timed events held in a row of slot cells.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in_ stream, one transfer per command, with the
// operation in in_tuser. Every command but a tick loads one result into the
// output register in the response state, after the evaluate state.
// A tick marks all expired slots in the evaluate state, then a count pass
// retires each expired slot from the pending count and an emit pass sends
// the id of each expired slot. Both passes are set by the first-flag chain
// through the cells, which picks one slot per cycle in slot order; the emit
// pass waits while the output register is held. A tick with nothing expired
// gives one result with out_tuser low. The last result of every command
// carries out_tlast.
// A new command is taken as soon as the previous one has loaded its last
// result, even while that result still waits for out_tready; a stalled
// receiver holds the output register and the sequencer waits behind it.
// Reset clears all valid bits and the pending count at once; slot contents
// are only read while valid, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module timed_event_expiry_table_unit #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: event_id[15:0], delay_ms[47:16], current_time[79:48]
  input  logic [teet_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: operation[2:0]
  input  logic [teet_pkg::OP_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: expired_id[15:0], status[17:16], pending_count[22:18], zero[23]
  output logic [teet_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: expired_valid[0]
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import teet_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_COUNT = 5'b00100,
    S_EMIT  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [ID_W-1:0]      key_r, key_nxt;
  logic [TIME_BITS-1:0] delay_r, delay_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic                 out_expv_r, out_expv_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                 out_last_r, out_last_nxt;

  cell_ctl_t            ctl;
  chain_t               chain [ENTRIES+1];
  cell_stat_t           stat  [ENTRIES];
  logic [ID_W-1:0]      cell_key [ENTRIES];

  logic                 hit_any, cnt_any, emit_any, emit_rest_any;
  logic [ID_W-1:0]      emit_key;
  logic                 in_xfer, out_free;

  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    teet_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cmd_key   (key_r),
      .cmd_now   (now_r),
      .cmd_delay (delay_r),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .stat      (stat[i]),
      .key_out   (cell_key[i])
    );
  end

  // Keys enter one at a time, so at most one cell matches and at most one
  // cell drives a nonzero key.
  always_comb begin
    hit_any       = 1'b0;
    cnt_any       = 1'b0;
    emit_any      = 1'b0;
    emit_rest_any = 1'b0;
    emit_key      = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_any       = hit_any | stat[i].match;
      cnt_any       = cnt_any | stat[i].cnt_flag;
      emit_any      = emit_any | stat[i].emit_flag;
      emit_rest_any = emit_rest_any | stat[i].emit_rest;
      emit_key      = emit_key | cell_key[i];
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    delay_nxt      = delay_r;
    now_nxt        = now_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_id_nxt     = out_id_r;
    out_expv_nxt   = out_expv_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    ctl            = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_tuser;
          key_nxt   = in_tdata[15:0];
          delay_nxt = TIME_BITS'(in_tdata[47:16]);
          now_nxt   = TIME_BITS'(in_tdata[79:48]);
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        status_nxt = ST_DONE;
        state_nxt  = S_RESP;
        case (op_r)
          OP_ENQUEUE: begin
            if (hit_any) begin
              ctl.load_hit = 1'b1;
              status_nxt   = ST_REARM;
            end else if (chain[ENTRIES].free_seen) begin
              ctl.load_free = 1'b1;
              count_nxt     = CNT_W'(count_r + 1'b1);
            end else begin
              status_nxt = ST_FULL;
            end
          end
          OP_UPDATE: begin
            if (hit_any) begin
              ctl.set_delay = 1'b1;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          OP_REMOVE: begin
            if (hit_any) begin
              ctl.kill_hit = 1'b1;
              count_nxt    = CNT_W'(count_r - 1'b1);
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          OP_TICK: begin
            ctl.tick_mark = 1'b1;
            state_nxt     = S_COUNT;
          end
          OP_CLEAR: begin
            ctl.clear_all = 1'b1;
            count_nxt     = '0;
          end
          default: begin
          end
        endcase
      end
      S_COUNT: begin
        if (cnt_any) begin
          ctl.cnt_step = 1'b1;
          count_nxt    = CNT_W'(count_r - 1'b1);
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_cnt_nxt    = count_r;
          if (emit_any) begin
            ctl.emit_step = 1'b1;
            out_id_nxt    = emit_key;
            out_expv_nxt  = 1'b1;
            out_last_nxt  = !emit_rest_any;
            if (!emit_rest_any) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_id_nxt   = '0;
            out_expv_nxt = 1'b0;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = '0;
          out_expv_nxt   = 1'b0;
          out_status_nxt = status_r;
          out_cnt_nxt    = count_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    delay_r      <= delay_nxt;
    now_r        <= now_nxt;
    status_r     <= status_nxt;
    out_id_r     <= out_id_nxt;
    out_expv_r   <= out_expv_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, PCOUNT_W'(out_cnt_r), out_status_r, out_id_r};
  assign out_tuser  = out_expv_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/teet_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teet_checker
// Port-level checks on the result stream of the timed event expiry table.
// ----------------------------------------------------------------------------
module teet_checker #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [teet_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [teet_pkg::OP_W-1:0]          in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [teet_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               out_tuser,
  input  logic                               out_tlast
);
  import teet_pkg::*;

  logic unused_in;
  assign unused_in = ^{in_tvalid, in_tready, in_tdata, in_tuser};

  // A stalled result transfer keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A result without an expired id is always the only result of its command.
  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[15:0] == '0))
    else $error("plain result not last or has nonzero id");

  // Expired ids come from ticks and always report done.
  a_expired_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[17:16] == ST_DONE)
    else $error("expired id with nonzero status");

  // The pending count never exceeds the table size; checked below 31 entries.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ENTRIES >= 31) || (int'(out_tdata[22:18]) <= ENTRIES))
    else $error("pending count above table size");

endmodule

bind timed_event_expiry_table_unit teet_checker #(.ENTRIES(ENTRIES)) u_teet_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
